@@ hdl/azimuth_unwrap_antiwindup_error_unit_defines.svh @@
// Assertion macros shared by the azimuth unwrap and windup error unit.
`ifndef AZIMUTH_UNWRAP_ANTIWINDUP_ERROR_UNIT_DEFINES_SVH
`define AZIMUTH_UNWRAP_ANTIWINDUP_ERROR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AUWE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define AUWE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/auwe_pkg.sv @@
// Shared constants, types and the wrapped-difference function of the azimuth unwrap unit.
package auwe_pkg;

    localparam int MAX_TURNS     = 4;
    localparam int HALF_TURN     = 1800;
    localparam int FULL_TURN     = 3600;
    localparam int TURN_LIM      = MAX_TURNS * FULL_TURN;
    localparam int ANGLE_OUT_MAX = 16383;

    localparam int AZ_W      = 12;
    localparam int DIFF_W    = AZ_W + 1;
    localparam int ANG_OUT_W = 15;
    localparam int LIM_W     = 13;
    localparam int REL_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = LIM_W;

    // Offset holds +-TURN_LIM plus one turn before the clamp.
    localparam int OFS_W = $clog2(TURN_LIM + FULL_TURN + 1) + 1;
    localparam int ANG_W = OFS_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIP_LEVEL        = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_THRESHOLD = CFG_IDX_W'(1);

    localparam logic [LIM_W-1:0] LIM_RST = LIM_W'(4500);
    localparam logic [REL_W-1:0] REL_RST = REL_W'(1750);

    typedef logic signed [AZ_W-1:0] t_angle;

    typedef struct packed {
        t_angle                      az_error;
        logic signed [ANG_OUT_W-1:0] windup_angle;
        logic                        windup_active;
    } t_az_res;

    // Target minus measured, folded once into the half-turn range.
    function automatic t_angle wrap_diff(t_angle a, t_angle b);
        logic signed [DIFF_W-1:0] d;
        logic signed [DIFF_W-1:0] half;
        half = DIFF_W'(HALF_TURN);
        d    = DIFF_W'(a) - DIFF_W'(b);
        if (d < -half) begin
            d = d + DIFF_W'(FULL_TURN);
        end else if (d > half) begin
            d = d - DIFF_W'(FULL_TURN);
        end
        return d[AZ_W-1:0];
    endfunction

endpackage

@@ hdl/auwe_unwrap.sv @@
// Azimuth unwrap state, windup flag and azimuth error for one tick.
module auwe_unwrap
    import auwe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_angle           i_az,
    input  t_angle           i_az_target,
    input  logic [LIM_W-1:0] i_trip_level,
    input  logic [REL_W-1:0] i_release,
    output t_az_res          o_res
);

    localparam logic signed [DIFF_W-1:0] HALF_D  = DIFF_W'(HALF_TURN);
    localparam logic signed [OFS_W-1:0]  FULL_O  = OFS_W'(FULL_TURN);
    localparam logic signed [OFS_W-1:0]  LIM_O   = OFS_W'(TURN_LIM);
    localparam logic signed [ANG_W-1:0]  HALF_A  = ANG_W'(HALF_TURN);
    localparam logic signed [ANG_W-1:0]  OUTMX_A = ANG_W'(ANGLE_OUT_MAX);

    t_angle                   r_last_az;
    logic signed [OFS_W-1:0]  r_ofs;
    logic                     r_flag;
    logic signed [OFS_W-1:0]  n_ofs;
    logic                     n_flag;

    logic signed [DIFF_W-1:0] w_step;
    logic signed [OFS_W-1:0]  w_ofs_sum;
    logic signed [ANG_W-1:0]  w_angle;
    logic [ANG_W-1:0]         w_angle_mag;
    logic                     w_flag_set;
    t_angle                   w_az_clamp;
    logic [AZ_W-1:0]          w_clamp_abs;
    logic signed [ANG_OUT_W-1:0] w_angle_out;

    always_comb begin
        w_step    = DIFF_W'(i_az) - DIFF_W'(r_last_az);
        w_ofs_sum = r_ofs;
        if (w_step < -HALF_D) begin
            w_ofs_sum = r_ofs + FULL_O;
        end else if (w_step > HALF_D) begin
            w_ofs_sum = r_ofs - FULL_O;
        end
        // saturate the turn count
        if (w_ofs_sum > LIM_O) begin
            n_ofs = LIM_O;
        end else if (w_ofs_sum < -LIM_O) begin
            n_ofs = -LIM_O;
        end else begin
            n_ofs = w_ofs_sum;
        end

        w_angle     = ANG_W'(i_az) + ANG_W'(n_ofs);
        w_angle_mag = (w_angle < 0) ? ANG_W'(-w_angle) : ANG_W'(w_angle);
        w_flag_set  = r_flag | (w_angle_mag > ANG_W'(i_trip_level));

        if (w_angle > HALF_A) begin
            w_az_clamp = AZ_W'(HALF_TURN);
        end else if (w_angle < -HALF_A) begin
            w_az_clamp = -AZ_W'(HALF_TURN);
        end else begin
            w_az_clamp = w_angle[AZ_W-1:0];
        end
        w_clamp_abs = (w_az_clamp < 0) ? AZ_W'(-w_az_clamp) : AZ_W'(w_az_clamp);
        n_flag      = w_flag_set & ~(w_clamp_abs[REL_W-1:0] < i_release);

        if (w_angle > OUTMX_A) begin
            w_angle_out = ANG_OUT_W'(ANGLE_OUT_MAX);
        end else if (w_angle < -OUTMX_A) begin
            w_angle_out = -ANG_OUT_W'(ANGLE_OUT_MAX);
        end else begin
            w_angle_out = w_angle[ANG_OUT_W-1:0];
        end

        o_res.az_error      = w_flag_set ? w_az_clamp : wrap_diff(i_az_target, i_az);
        o_res.windup_angle  = w_angle_out;
        o_res.windup_active = n_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_az <= '0;
            r_ofs     <= '0;
            r_flag    <= 1'b0;
        end else if (i_en) begin
            r_last_az <= i_az;
            r_ofs     <= n_ofs;
            r_flag    <= n_flag;
        end
    end

endmodule

@@ hdl/azimuth_unwrap_antiwindup_error_unit.sv @@
// Azimuth unwrap with cable windup limit: top level with stream ports and registers.
//
// Takes one position tick per beat (measured and target azimuth and elevation,
// signed tenths of a degree) and returns one result beat per tick: azimuth error,
// wrapped elevation error, unwrapped azimuth from home and the windup flag.
// Azimuth is unwrapped by tracking whole turns (+-3600 per step larger than
// half a turn), the turn offset saturating at MAX_TURNS turns. Once the
// unwrapped angle magnitude passes the trip level register (index 0) the unit
// reports the unwind error (unwrapped angle clamped to +-1800) until that error
// drops below release_threshold. Throughput is one beat per clock cycle while the
// result side keeps m_axis_tready high. A tick is held in the input register;
// the unwrap and error logic, which updates the turn state as the tick advances
// out of it, then feeds the result register, which registers the result and
// raises result valid for downstream to take. A new tick can enter the input
// register as the held one advances. The turn-state update done at each advance
// is what sets that rate. Write registers only while no beat is in flight.
`include "azimuth_unwrap_antiwindup_error_unit_defines.svh"

module azimuth_unwrap_antiwindup_error_unit
    import auwe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // register write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // tick input
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: az_measured[11:0], el_measured[23:12], az_target[35:24], el_target[47:36]
    input  logic [47:0]          s_axis_tdata,
    // result output
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata: az_error[11:0], el_error[23:12], windup_angle[38:24], zero pad[39]
    output logic [39:0]          m_axis_tdata,
    // tuser: windup_active[0]
    output logic                 m_axis_tuser
);

    logic [LIM_W-1:0] r_cfg_limit;
    logic [REL_W-1:0] r_cfg_rel;

    logic   r_in_valid;
    t_angle r_az_meas;
    t_angle r_el_meas;
    t_angle r_az_tgt;
    t_angle r_el_tgt;

    logic                        r_out_valid;
    t_angle                      r_out_az_err;
    t_angle                      r_out_el_err;
    logic signed [ANG_OUT_W-1:0] r_out_angle;
    logic                        r_out_active;

    logic    w_advance;
    logic    w_in_take;
    t_az_res w_az_res;

    // Move the held tick into the result register when that slot frees up.
    assign w_advance     = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | w_advance;
    assign w_in_take     = s_axis_tvalid & s_axis_tready;

    // Register writes: the index picks the register, data is cut to its width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_limit <= LIM_RST;
            r_cfg_rel   <= REL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRIP_LEVEL:        r_cfg_limit <= i_cfg_data[LIM_W-1:0];
                CFG_RELEASE_THRESHOLD: r_cfg_rel   <= i_cfg_data[REL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: hold a beat until the unwrap stage takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_az_meas <= s_axis_tdata[11:0];
            r_el_meas <= s_axis_tdata[23:12];
            r_az_tgt  <= s_axis_tdata[35:24];
            r_el_tgt  <= s_axis_tdata[47:36];
        end
    end

    // Unwrap, windup flag and azimuth error; state advances with the beat.
    auwe_unwrap u_unwrap (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_advance),
        .i_az           (r_az_meas),
        .i_az_target    (r_az_tgt),
        .i_trip_level   (r_cfg_limit),
        .i_release      (r_cfg_rel),
        .o_res          (w_az_res)
    );

    // Result register: drop valid once the beat is taken downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_az_err <= w_az_res.az_error;
            r_out_el_err <= wrap_diff(r_el_tgt, r_el_meas);
            r_out_angle  <= w_az_res.windup_angle;
            r_out_active <= w_az_res.windup_active;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_angle, r_out_el_err, r_out_az_err};
    assign m_axis_tuser  = r_out_active;

    // A tick that cannot advance stays in the input register.
    `AUWE_ASSERT_NEXT(a_in_hold, r_in_valid && !w_advance, r_in_valid,
        "input beat lost while stalled")

    // Every advanced tick shows up as a result beat.
    `AUWE_ASSERT_NEXT(a_out_fill, w_advance, r_out_valid,
        "advanced beat did not reach the result register")

    // While unwinding, the azimuth error is the clamped unwrapped angle.
    `AUWE_ASSERT_NOW(a_unwind_err, r_out_valid && r_out_active,
        (r_out_angle > ANG_OUT_W'(HALF_TURN)) ? (r_out_az_err == AZ_W'(HALF_TURN)) :
        (r_out_angle < -ANG_OUT_W'(HALF_TURN)) ? (r_out_az_err == -AZ_W'(HALF_TURN)) :
        (r_out_az_err == r_out_angle[AZ_W-1:0]),
        "unwind error does not match unwrapped angle")

endmodule

@@ verif/tb_azimuth_unwrap_antiwindup_error_unit.sv @@
// Self-checking testbench for the azimuth unwrap and cable windup error unit.
`timescale 1ns / 1ps

module tb_azimuth_unwrap_antiwindup_error_unit;
    import auwe_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SINK_HOLD   = 200;   // long receiver hold-off, in cycles
    localparam int DRAIN_TAIL  = 8;     // cycles past the last result

    // One expected result beat, field by field.
    typedef struct {
        t_angle                      az_err;
        t_angle                      el_err;
        logic signed [ANG_OUT_W-1:0] unwrapped;
        logic                        active;
    } t_pointing;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata;   // az_measured, el_measured, az_target, el_target
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [39:0]          m_axis_tdata;   // az_error, el_error, windup_angle, zero pad
    logic                 m_axis_tuser;   // windup_active

    // Tracker copy of the unit's state and registers.
    t_angle           trk_last_az;
    int               trk_turns;
    logic             trk_windup;
    logic [LIM_W-1:0] cfg_limit;
    logic [REL_W-1:0] cfg_release;

    t_pointing expected_pointing[$];
    t_pointing want_p;

    int  failures      = 0;
    int  cycle_count   = 0;
    int  src_idle_pct  = 20;
    int  sink_idle_pct = 20;
    bit  sink_hold_req = 1'b0;
    int  walk_az       = 0;
    int  walk_dir      = 1;

    azimuth_unwrap_antiwindup_error_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int abs_int(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Target minus measured, folded by one turn at most.
    function automatic int shortest_diff(int tgt, int meas);
        int d;
        d = tgt - meas;
        if (d < -HALF_TURN) d += FULL_TURN;
        if (d > HALF_TURN) d -= FULL_TURN;
        return d;
    endfunction

    // Advance the tracker by one tick and return the result it must produce.
    function automatic t_pointing predict_pointing(t_angle az, t_angle el,
                                                   t_angle az_set, t_angle el_set);
        t_pointing r;
        int        step;
        int        angle;
        int        err;
        step = int'(az) - int'(trk_last_az);
        if (step < -HALF_TURN) trk_turns += FULL_TURN;
        if (step > HALF_TURN) trk_turns -= FULL_TURN;
        trk_turns   = clamp_int(trk_turns, -TURN_LIM, TURN_LIM);
        trk_last_az = az;

        angle = int'(az) + trk_turns;
        if (abs_int(angle) > int'(cfg_limit)) trk_windup = 1'b1;
        // Unwinding: report the clamped home offset; the flag may drop in this same tick.
        if (trk_windup) begin
            err = clamp_int(angle, -HALF_TURN, HALF_TURN);
            if (abs_int(err) < int'(cfg_release)) trk_windup = 1'b0;
        end else begin
            err = shortest_diff(int'(az_set), int'(az));
        end
        r.az_err    = t_angle'(err);
        r.el_err    = t_angle'(shortest_diff(int'(el_set), int'(el)));
        r.unwrapped = ANG_OUT_W'(clamp_int(angle, -ANGLE_OUT_MAX, ANGLE_OUT_MAX));
        r.active    = trk_windup;
        return r;
    endfunction

    // Mostly in-range angles, sometimes any 12-bit code.
    function automatic t_angle rand_angle();
        if ($urandom_range(99) < 80) return t_angle'(int'($urandom_range(3600)) - HALF_TURN);
        return t_angle'($urandom_range(4095));
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // Result monitor: compare each result beat with the oldest pending tick.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pointing.size() == 0) begin
                $error("result beat with no tick pending: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                failures++;
            end else begin
                want_p = expected_pointing.pop_front();
                check_field("az_error", int'(want_p.az_err), int'($signed(m_axis_tdata[11:0])));
                check_field("el_error", int'(want_p.el_err), int'($signed(m_axis_tdata[23:12])));
                check_field("windup_angle", int'(want_p.unwrapped),
                            int'($signed(m_axis_tdata[38:24])));
                check_field("pad", 0, int'(m_axis_tdata[39]));
                check_field("windup_active", int'(want_p.active), int'(m_axis_tuser));
            end
        end
    end

    // Receiver: random ready, or a long hold-off when a test asks for one.
    initial begin
        int held;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (held = 1; held < SINK_HOLD; held++) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Offer one tick, hold it until accepted, then record its expected result.
    task automatic send_tick(t_angle az, t_angle el, t_angle az_set, t_angle el_set);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {el_set, az_set, el, az};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_pointing.push_back(predict_pointing(az, el, az_set, el_set));
    endtask

    // Drop valid and wait until every pending result has come out.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_pointing.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // Write both registers while the unit is idle.
    task automatic apply_settings(int unsigned limit, int unsigned release_lvl);
        wait_for_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TRIP_LEVEL;
        i_cfg_data  <= CFG_DAT_W'(limit);
        @(posedge i_clk);
        i_cfg_index <= CFG_RELEASE_THRESHOLD;
        i_cfg_data  <= CFG_DAT_W'(release_lvl);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_limit   = LIM_W'(limit);
        cfg_release = REL_W'(release_lvl);
    endtask

    // Random rotation: mostly a continuous walk that crosses the seam both ways,
    // with occasional jumps anywhere in the 12-bit range.
    task automatic spin_ticks(int count);
        t_angle az;
        int     n;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0) begin
                az      = t_angle'($urandom_range(4095));
                walk_az = clamp_int(int'(az), -HALF_TURN, HALF_TURN);
            end else begin
                if ($urandom_range(99) < 3) walk_dir = -walk_dir;
                walk_az += walk_dir * int'($urandom_range(900));
                if (walk_az > HALF_TURN) walk_az -= FULL_TURN;
                if (walk_az < -HALF_TURN) walk_az += FULL_TURN;
                az = t_angle'(walk_az);
            end
            send_tick(az, rand_angle(), rand_angle(), rand_angle());
        end
    endtask

    // Field extremes on both sides of the seam, including codes past +-1800.
    task automatic test_field_extremes();
        int ticks [6][4] = '{
            '{    0,     0,     0,     0},
            '{ 1800, -1800, -1800,  1800},
            '{-1800,  1800,  1800, -1800},
            '{ 2047, -2048, -2048,  2047},
            '{-2048,  2047,  2047, -2048},
            '{    1,    -1,    -1,     1}
        };
        int k;
        for (k = 0; k < 6; k++)
            send_tick(t_angle'(ticks[k][0]), t_angle'(ticks[k][1]),
                      t_angle'(ticks[k][2]), t_angle'(ticks[k][3]));
    endtask

    // Spin forward past the turn limit so the offset saturates and windup sets,
    // then land on the largest code so the angle output saturates too.
    task automatic test_turn_saturation();
        int k;
        for (k = 0; k < 6; k++) begin
            send_tick(-12'sd1200, 12'sd0, 12'sd0, 12'sd0);
            send_tick(12'sd0, 12'sd0, 12'sd0, 12'sd0);
            send_tick(12'sd1200, 12'sd0, 12'sd0, 12'sd0);
        end
        send_tick(12'sd2047, 12'sd0, 12'sd0, 12'sd0);
        walk_az  = HALF_TURN;
        walk_dir = -1;
    endtask

    // Walk through several register settings, extremes included; a zero limit
    // with a high release lets windup set and clear in one tick.
    task automatic test_register_settings();
        int settings [6][2] = '{
            '{   0, 1800},
            '{7200,    0},
            '{8191, 2047},
            '{   0,    0},
            '{3000, 1000},
            '{7200, 1800}
        };
        int k;
        for (k = 0; k < 6; k++) begin
            apply_settings(settings[k][0], settings[k][1]);
            spin_ticks(80);
        end
    endtask

    // Hold the receiver off while ticks stream in back to back, so the unit
    // fills and stalls its input; then pause until everything has drained.
    task automatic test_backpressure();
        apply_settings(4500, 1750);
        src_idle_pct  = 0;
        sink_hold_req = 1'b1;
        spin_ticks(60);
        wait_for_drain();
        src_idle_pct  = 20;
    endtask

    // Bulk random rotation with a stretch where neither side idles.
    task automatic test_random_rotation();
        spin_ticks(250);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        spin_ticks(200);
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        apply_settings(2500, 600);
        spin_ticks(250);
        apply_settings(4500, 1750);
        spin_ticks(300);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_TRIP_LEVEL;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        trk_last_az   = '0;
        trk_turns     = 0;
        trk_windup    = 1'b0;
        cfg_limit     = LIM_RST;
        cfg_release   = REL_RST;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_turn_saturation();
        test_register_settings();
        test_backpressure();
        test_random_rotation();
        wait_for_drain();

        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/auwe_pkg.sv
hdl/auwe_unwrap.sv
hdl/azimuth_unwrap_antiwindup_error_unit.sv
verif/tb_azimuth_unwrap_antiwindup_error_unit.sv
